FILE: rtl/core/sws_pkg.sv
`timescale 1ns / 1ps
package sws_pkg;

   // Default sizes and fixed-point format.
   localparam int MAX_COLS_DEF  = 256;
   localparam int MAX_ROWS_DEF  = 256;
   localparam int FRAC_BITS_DEF = 16;

   // Register field widths and the CSR bus.
   localparam int CFG_W    = 9;
   localparam int LAMBDA_W = 16;
   localparam int GRAV_W   = 20;
   localparam int WALL_W   = 4;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;

   // Register reset values.
   localparam logic [CFG_W-1:0]    COLS_RST = 9'd200;
   localparam logic [CFG_W-1:0]    ROWS_RST = 9'd200;
   localparam logic [LAMBDA_W-1:0] LX_RST   = 16'd2621;
   localparam logic [LAMBDA_W-1:0] LY_RST   = 16'd2621;
   localparam logic [GRAV_W-1:0]   GRAV_RST = 20'd321454;
   localparam logic [WALL_W-1:0]   WALL_RST = 4'hF;

   // Wall mask bit positions.
   localparam int WALL_TOP   = 0;
   localparam int WALL_BOT   = 1;
   localparam int WALL_LEFT  = 2;
   localparam int WALL_RIGHT = 3;

   // Register index, taken from the word address.
   typedef enum logic [2:0] {
      REG_COLS = 3'd0,
      REG_ROWS = 3'd1,
      REG_LX   = 3'd2,
      REG_LY   = 3'd3,
      REG_GRAV = 3'd4,
      REG_WALL = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic signed [31:0] cell_depth;
      logic signed [31:0] cell_xmom;
      logic signed [31:0] cell_ymom;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_depth;
      logic signed [31:0] new_xmom;
      logic signed [31:0] new_ymom;
      logic [7:0]         out_row;
      logic [7:0]         out_col;
      logic               frame_end;
      logic               depth_fault;
   } rsp_type;

   // One line store word: a cell and its three fluxes.
   typedef struct packed {
      logic signed [31:0] h;
      logic signed [31:0] u;
      logic signed [31:0] v;
      logic signed [31:0] fx;
      logic signed [31:0] cr;
      logic signed [31:0] fy;
   } cell_type;

   // Saturate a wide signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] val);
      logic signed [31:0] res;
      if (val > 64'sd2147483647) begin
         res = 32'sh7FFF_FFFF;
      end else if (val < -64'sd2147483648) begin
         res = 32'sh8000_0000;
      end else begin
         res = val[31:0];
      end
      return res;
   endfunction

   // Magnitude of a signed 32-bit value as unsigned.
   function automatic logic [31:0] uabs32(input logic signed [31:0] val);
      logic [31:0] res;
      res = val[31] ? (~val + 32'd1) : val;
      return res;
   endfunction

endpackage

FILE: rtl/core/shallow_water_stencil_step.sv
`timescale 1ns / 1ps
// A cell is worked on alone: an accepted beat runs the momentum product and the bit-serial
// 64-step divider once for each of the three flux quotients (skipped when the depth is not
// positive), then the pressure steps, the line store reads and write, the neighbor sums and
// the three update passes; no new beat is taken until the cell is done, and a stalled result
// beat holds the block. A halo cell gives no result and returns to idle after its write.
// Reset (synchronous) clears control, raster position and configuration registers, not the line store.
module shallow_water_stencil_step #(
   parameter int MAX_COLS  = sws_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS  = sws_pkg::MAX_ROWS_DEF,
   parameter int FRAC_BITS = sws_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  sws_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output sws_pkg::rsp_type            rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [sws_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [sws_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [sws_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import sws_pkg::*;

   localparam int LINE  = MAX_COLS + 2;
   localparam int DEPTH = 2 * LINE;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_COLS + 3);
   localparam int RW    = $clog2(MAX_ROWS + 3);
   localparam int BPW   = FRAC_BITS + GRAV_W;

   typedef enum logic [13:0] {
      ST_IDLE = 14'b00000000000001,
      ST_MUL  = 14'b00000000000010,
      ST_DIV  = 14'b00000000000100,
      ST_DFIN = 14'b00000000001000,
      ST_PRS1 = 14'b00000000010000,
      ST_PRS2 = 14'b00000000100000,
      ST_PRS3 = 14'b00000001000000,
      ST_RD   = 14'b00000010000000,
      ST_WR   = 14'b00000100000000,
      ST_NB   = 14'b00001000000000,
      ST_UPA  = 14'b00010000000000,
      ST_UPB  = 14'b00100000000000,
      ST_UPC  = 14'b01000000000000,
      ST_OUT  = 14'b10000000000000
   } state_type;

   typedef struct packed {
      logic signed [32:0] h;
      logic signed [32:0] u;
      logic signed [32:0] v;
      logic signed [32:0] fx;
      logic signed [32:0] cr;
      logic signed [32:0] fy;
   } wide_cell_type;

   function automatic wide_cell_type widen(input cell_type c);
      wide_cell_type w;
      w.h  = 33'(c.h);
      w.u  = 33'(c.u);
      w.v  = 33'(c.v);
      w.fx = 33'(c.fx);
      w.cr = 33'(c.cr);
      w.fy = 33'(c.fy);
      return w;
   endfunction

   // Configuration registers.
   logic [CFG_W-1:0]    cols_cfg_ff, rows_cfg_ff;
   logic [LAMBDA_W-1:0] lx_ff, ly_ff;
   logic [GRAV_W-1:0]   grav_ff;
   logic [WALL_W-1:0]   wall_ff;
   logic                csr_wr;
   reg_index_type       csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_cfg_ff <= COLS_RST;
         rows_cfg_ff <= ROWS_RST;
         lx_ff       <= LX_RST;
         ly_ff       <= LY_RST;
         grav_ff     <= GRAV_RST;
         wall_ff     <= WALL_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_COLS: cols_cfg_ff <= csr_pwdata[CFG_W-1:0];
            REG_ROWS: rows_cfg_ff <= csr_pwdata[CFG_W-1:0];
            REG_LX:   lx_ff       <= csr_pwdata[LAMBDA_W-1:0];
            REG_LY:   ly_ff       <= csr_pwdata[LAMBDA_W-1:0];
            REG_GRAV: grav_ff     <= csr_pwdata[GRAV_W-1:0];
            REG_WALL: wall_ff     <= csr_pwdata[WALL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_COLS: csr_prdata = DATA_W'(cols_cfg_ff);
         REG_ROWS: csr_prdata = DATA_W'(rows_cfg_ff);
         REG_LX:   csr_prdata = DATA_W'(lx_ff);
         REG_LY:   csr_prdata = DATA_W'(ly_ff);
         REG_GRAV: csr_prdata = DATA_W'(grav_ff);
         REG_WALL: csr_prdata = DATA_W'(wall_ff);
         default:  csr_prdata = '0;
      endcase
   end

   // Tile geometry and raster position of the arriving cell.
   logic [CW-1:0] col_ff;
   logic [RW-1:0] row_ff;
   logic [31:0]   cols_w, rows_w, wid_w, hgt_w, r_w, c_w, nr_w, nc_w;
   logic          interior_w;

   always_comb begin
      if (cols_cfg_ff == '0) begin
         cols_w = 32'd1;
      end else if (32'(cols_cfg_ff) > 32'(MAX_COLS)) begin
         cols_w = 32'(MAX_COLS);
      end else begin
         cols_w = 32'(cols_cfg_ff);
      end
      if (rows_cfg_ff == '0) begin
         rows_w = 32'd1;
      end else if (32'(rows_cfg_ff) > 32'(MAX_ROWS)) begin
         rows_w = 32'(MAX_ROWS);
      end else begin
         rows_w = 32'(rows_cfg_ff);
      end
      wid_w = cols_w + 32'd2;
      hgt_w = rows_w + 32'd2;
      r_w   = 32'(row_ff);
      c_w   = (32'(col_ff) >= 32'(LINE)) ? 32'd0 : 32'(col_ff);
      interior_w = (r_w >= 32'd2) && (r_w <= hgt_w - 32'd1) &&
                   (c_w >= 32'd1) && (c_w <= wid_w - 32'd2);
      if (c_w + 32'd1 >= wid_w) begin
         nc_w = 32'd0;
         nr_w = r_w + 32'd1;
      end else begin
         nc_w = c_w + 32'd1;
         nr_w = r_w;
      end
      if (nr_w >= hgt_w) begin
         nr_w = 32'd0;
      end
   end

   // Control.
   state_type state_ff, state_in;
   logic [1:0] qk_ff, uk_ff;
   logic [5:0] dcnt_ff;
   logic [2:0] rd_cnt_ff;
   logic       rsp_valid_ff;
   logic       accept, rsp_load;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign rsp_load  = (state_ff == ST_OUT) & (~rsp_valid_ff | rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   // Item registers.
   req_type         in_ff;
   logic [CW-1:0]   pos_c_ff;
   logic            par_ff, interior_ff, frame_ff;
   logic            wl_ff, wr_ff, wb_ff, wt_ff;
   logic [7:0]      orow_ff, ocol_ff;

   // Datapath registers.
   logic [63:0]            dq_ff, mm_ff;
   logic [30:0]            rem_ff;
   logic                   qneg_ff, big_ff;
   logic signed [31:0]     q_ff [3];
   logic [51:0]            ah_ff;
   logic [GRAV_W-1:0]      bh_ff;
   cell_type               cur_ff;
   cell_type               nb_ff [4];
   logic signed [35:0]     sum_ff [3];
   logic signed [35:0]     df_ff [3];
   logic signed [35:0]     dg_ff [3];
   logic                   fault_ff;
   logic signed [52:0]     px_ff, py_ff;
   logic signed [31:0]     res_ff [3];
   rsp_type                rsp_data_ff;

   assign rsp_data = rsp_data_ff;

   // Quotient operands for the cross, x and y flux terms.
   logic signed [31:0] opa_w, opb_w;
   always_comb begin
      case (qk_ff)
         2'd0:    begin opa_w = in_ff.cell_xmom; opb_w = in_ff.cell_ymom; end
         2'd1:    begin opa_w = in_ff.cell_xmom; opb_w = in_ff.cell_xmom; end
         default: begin opa_w = in_ff.cell_ymom; opb_w = in_ff.cell_ymom; end
      endcase
   end

   logic depth_pos;
   assign depth_pos = (in_ff.cell_depth > 32'sd0);

   // One restoring divider step.
   logic [31:0] rem_sh, dvs;
   logic        ge;
   assign rem_sh = {rem_ff, dq_ff[63]};
   assign dvs    = {1'b0, in_ff.cell_depth[30:0]};
   assign ge     = (rem_sh >= dvs);

   // Pressure terms.
   logic [63:0]          a_w;
   logic [BPW-1:0]       bp_w;
   logic [52:0]          ps_w;
   logic signed [31:0]   pres_w;
   assign a_w  = mm_ff >> (2 * FRAC_BITS);
   assign bp_w = BPW'(mm_ff[2*FRAC_BITS-1:FRAC_BITS]) * BPW'(grav_ff);
   assign ps_w = {1'b0, ah_ff} + 53'(bh_ff);
   always_comb begin
      if (grav_ff == '0) begin
         pres_w = '0;
      end else if (big_ff || (ps_w > 53'd2147483647)) begin
         pres_w = 32'sh7FFF_FFFF;
      end else begin
         pres_w = ps_w[31:0];
      end
   end

   // Line store addresses.
   logic [31:0]   base_cur, base_prev;
   logic [AW-1:0] ra, wa;
   assign base_cur  = par_ff ? 32'(LINE) : 32'd0;
   assign base_prev = par_ff ? 32'd0 : 32'(LINE);
   assign wa        = AW'(base_cur + 32'(pos_c_ff));
   always_comb begin
      case (rd_cnt_ff)
         3'd0:    ra = AW'(base_prev + 32'(pos_c_ff) - 32'd1);
         3'd1:    ra = AW'(base_prev + 32'(pos_c_ff));
         3'd2:    ra = AW'(base_prev + 32'(pos_c_ff) + 32'd1);
         default: ra = AW'(base_cur + 32'(pos_c_ff));
      endcase
   end

   // Line store: two rows of cells and fluxes.
   cell_type mem [DEPTH];
   cell_type rd_data_ff;
   logic     mem_we;
   assign mem_we = (state_ff == ST_WR);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wa] <= cur_ff;
      end
      rd_data_ff <= mem[ra];
   end

   // Neighbors with wall reflection.
   wide_cell_type ctr_w, hm_w, vm_w, lft_w, rgt_w, bot_w, top_w;
   always_comb begin
      ctr_w = widen(nb_ff[1]);
      hm_w  = ctr_w;
      vm_w  = ctr_w;
      hm_w.u  = -ctr_w.u;
      hm_w.cr = -ctr_w.cr;
      vm_w.v  = -ctr_w.v;
      vm_w.cr = -ctr_w.cr;
      lft_w = wl_ff ? hm_w : widen(nb_ff[0]);
      rgt_w = wr_ff ? hm_w : widen(nb_ff[2]);
      bot_w = wb_ff ? vm_w : widen(nb_ff[3]);
      top_w = wt_ff ? vm_w : widen(cur_ff);
   end

   // Update combine.
   logic signed [63:0] t_w, s_w;
   assign t_w = (64'(sum_ff[uk_ff]) <<< (FRAC_BITS - 2)) - 64'(px_ff) - 64'(py_ff);
   assign s_w = t_w >>> FRAC_BITS;

   // State sequencing.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_MUL;
         ST_MUL: begin
            if (depth_pos) begin
               state_in = ST_DIV;
            end else if (qk_ff == 2'd2) begin
               state_in = ST_PRS1;
            end
         end
         ST_DIV:  if (dcnt_ff == 6'd63) state_in = ST_DFIN;
         ST_DFIN: state_in = (qk_ff == 2'd2) ? ST_PRS1 : ST_MUL;
         ST_PRS1: state_in = ST_PRS2;
         ST_PRS2: state_in = ST_PRS3;
         ST_PRS3: state_in = interior_ff ? ST_RD : ST_WR;
         ST_RD:   if (rd_cnt_ff == 3'd4) state_in = ST_WR;
         ST_WR:   state_in = interior_ff ? ST_NB : ST_IDLE;
         ST_NB:   state_in = ST_UPA;
         ST_UPA:  state_in = ST_UPB;
         ST_UPB:  state_in = ST_UPC;
         ST_UPC:  state_in = (uk_ff == 2'd2) ? ST_OUT : ST_UPA;
         ST_OUT:  if (rsp_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         qk_ff        <= '0;
         uk_ff        <= '0;
         dcnt_ff      <= '0;
         rd_cnt_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            col_ff <= nc_w[CW-1:0];
            row_ff <= nr_w[RW-1:0];
            qk_ff  <= '0;
         end
         if ((state_ff == ST_MUL && !depth_pos) || state_ff == ST_DFIN) begin
            qk_ff <= qk_ff + 2'd1;
         end
         if (state_ff == ST_MUL) begin
            dcnt_ff <= '0;
         end else if (state_ff == ST_DIV) begin
            dcnt_ff <= dcnt_ff + 6'd1;
         end
         if (state_ff == ST_RD) begin
            rd_cnt_ff <= rd_cnt_ff + 3'd1;
         end else begin
            rd_cnt_ff <= '0;
         end
         if (state_ff == ST_NB) begin
            uk_ff <= '0;
         end else if (state_ff == ST_UPC) begin
            uk_ff <= uk_ff + 2'd1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      // Latch the beat and where it sits in the tile.
      if (accept) begin
         in_ff       <= req_data;
         pos_c_ff    <= c_w[CW-1:0];
         par_ff      <= r_w[0];
         interior_ff <= interior_w;
         frame_ff    <= (r_w == hgt_w - 32'd1) && (c_w == wid_w - 32'd2);
         wb_ff       <= (r_w == 32'd2) && wall_ff[WALL_BOT];
         wt_ff       <= (r_w == hgt_w - 32'd1) && wall_ff[WALL_TOP];
         wl_ff       <= (c_w == 32'd1) && wall_ff[WALL_LEFT];
         wr_ff       <= (c_w == wid_w - 32'd2) && wall_ff[WALL_RIGHT];
         orow_ff     <= 8'(r_w - 32'd2);
         ocol_ff     <= 8'(c_w - 32'd1);
      end

      // Momentum product, then the divider on its magnitude.
      if (state_ff == ST_MUL) begin
         dq_ff   <= 64'(uabs32(opa_w)) * 64'(uabs32(opb_w));
         qneg_ff <= opa_w[31] ^ opb_w[31];
         rem_ff  <= '0;
         if (!depth_pos) begin
            q_ff[qk_ff] <= '0;
         end
      end
      if (state_ff == ST_DIV) begin
         rem_ff <= ge ? 31'(rem_sh - dvs) : rem_sh[30:0];
         dq_ff  <= {dq_ff[62:0], ge};
      end
      if (state_ff == ST_DFIN) begin
         if (qneg_ff) begin
            q_ff[qk_ff] <= (dq_ff > 64'h8000_0000) ? 32'sh8000_0000 : -dq_ff[31:0];
         end else begin
            q_ff[qk_ff] <= (dq_ff > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : dq_ff[31:0];
         end
      end

      // Pressure and flux assembly.
      if (state_ff == ST_PRS1) begin
         mm_ff <= 64'(uabs32(in_ff.cell_depth)) * 64'(uabs32(in_ff.cell_depth));
      end
      if (state_ff == ST_PRS2) begin
         big_ff <= |a_w[63:32];
         ah_ff  <= 52'(a_w[31:0]) * 52'(grav_ff);
         bh_ff  <= bp_w[BPW-1:FRAC_BITS];
      end
      if (state_ff == ST_PRS3) begin
         cur_ff.h  <= in_ff.cell_depth;
         cur_ff.u  <= in_ff.cell_xmom;
         cur_ff.v  <= in_ff.cell_ymom;
         cur_ff.cr <= q_ff[0];
         cur_ff.fx <= sat32(64'(q_ff[1]) + 64'(pres_w));
         cur_ff.fy <= sat32(64'(q_ff[2]) + 64'(pres_w));
      end

      // Neighbor reads arrive in the cycle after their address.
      if (state_ff == ST_RD && rd_cnt_ff != 3'd0) begin
         nb_ff[2'(rd_cnt_ff - 3'd1)] <= rd_data_ff;
      end

      // Sums and flux differences of the three quantities.
      if (state_ff == ST_NB) begin
         sum_ff[0] <= 36'(lft_w.h) + 36'(rgt_w.h) + 36'(bot_w.h) + 36'(top_w.h);
         sum_ff[1] <= 36'(lft_w.u) + 36'(rgt_w.u) + 36'(bot_w.u) + 36'(top_w.u);
         sum_ff[2] <= 36'(lft_w.v) + 36'(rgt_w.v) + 36'(bot_w.v) + 36'(top_w.v);
         df_ff[0]  <= 36'(rgt_w.u) - 36'(lft_w.u);
         df_ff[1]  <= 36'(rgt_w.fx) - 36'(lft_w.fx);
         df_ff[2]  <= 36'(rgt_w.cr) - 36'(lft_w.cr);
         dg_ff[0]  <= 36'(top_w.v) - 36'(bot_w.v);
         dg_ff[1]  <= 36'(top_w.cr) - 36'(bot_w.cr);
         dg_ff[2]  <= 36'(top_w.fy) - 36'(bot_w.fy);
         fault_ff  <= (lft_w.h <= 33'sd0) || (rgt_w.h <= 33'sd0) ||
                      (bot_w.h <= 33'sd0) || (top_w.h <= 33'sd0);
      end

      // Lax-Friedrichs update, one quantity per pass.
      if (state_ff == ST_UPA) begin
         px_ff <= $signed({1'b0, lx_ff}) * df_ff[uk_ff];
      end
      if (state_ff == ST_UPB) begin
         py_ff <= $signed({1'b0, ly_ff}) * dg_ff[uk_ff];
      end
      if (state_ff == ST_UPC) begin
         res_ff[uk_ff] <= sat32(s_w);
      end

      // Result beat.
      if (rsp_load) begin
         rsp_data_ff.new_depth   <= res_ff[0];
         rsp_data_ff.new_xmom    <= res_ff[1];
         rsp_data_ff.new_ymom    <= res_ff[2];
         rsp_data_ff.out_row     <= orow_ff;
         rsp_data_ff.out_col     <= ocol_ff;
         rsp_data_ff.frame_end   <= frame_ff;
         rsp_data_ff.depth_fault <= fault_ff;
      end
   end

endmodule

FILE: rtl/core/sws_checker.sv
`timescale 1ns / 1ps
module sws_props (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sws_pkg::rsp_type rsp_data,
   input logic             csr_pready
);
   import sws_pkg::*;

   // A cell is worked on alone: no second beat right after one is taken.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready high right after an accepted beat");

   // A stalled result beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result beat changed");

   // No result can come out of reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The register port never waits.
   assert property (@(posedge clock) csr_pready)
      else $error("csr_pready low");

endmodule

bind shallow_water_stencil_step sws_props u_sws_props (.*);
